// ===== rtl/sarl_pkg.sv =====
// Shared types and constants for the symbol address range lookup block.
`default_nettype none

package sarl_pkg;

  localparam int SYMBOLS   = 1024;
  localparam int IDX_W     = $clog2(SYMBOLS);
  localparam int LIM_W     = $clog2(SYMBOLS + 1);
  localparam int DATA_W    = 64;
  localparam int ENTRY_W   = 10;
  localparam int MATCH_W   = 10;
  localparam int COUNT_W   = 11;
  localparam int SECTION_W = 16;
  localparam int KIND_W    = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [SECTION_W-1:0] SECTION_NONE = 16'd0;
  localparam logic [KIND_W-1:0]    STT_TLS      = 4'd6;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ADDR_OFFSET  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_COUNT = 2'd1;

  typedef struct packed {
    logic [DATA_W-1:0] start;
    logic [DATA_W-1:0] length;
    logic              usable;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic               valid;
    logic               found;
    logic [MATCH_W-1:0] index;
  } scan_res_t;

endpackage

`default_nettype wire

// ===== rtl/sarl_ifs.sv =====
// Channel interfaces: request items, response items and register writes.
`default_nettype none

interface sarl_in_if;
  logic                            valid;
  logic                            ready;
  logic                            command;
  logic [sarl_pkg::ENTRY_W-1:0]    entry_index;
  logic [sarl_pkg::DATA_W-1:0]     entry_start;
  logic [sarl_pkg::DATA_W-1:0]     entry_length;
  logic [sarl_pkg::SECTION_W-1:0]  entry_section;
  logic [sarl_pkg::KIND_W-1:0]     entry_kind;
  logic [sarl_pkg::DATA_W-1:0]     query_address;

  modport source (output valid, command, entry_index, entry_start, entry_length,
                  entry_section, entry_kind, query_address, input ready);
  modport sink   (input valid, command, entry_index, entry_start, entry_length,
                  entry_section, entry_kind, query_address, output ready);
endinterface

interface sarl_out_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [sarl_pkg::MATCH_W-1:0]  match_index;

  modport source (output valid, found, match_index, input ready);
  modport sink   (input valid, found, match_index, output ready);
endinterface

interface sarl_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sarl_pkg::CFG_IDX_W-1:0]  index;
  logic [sarl_pkg::DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/sarl_table.sv =====
// Symbol entry memory: one write port, one registered read port.
`default_nettype none

module sarl_table (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [sarl_pkg::IDX_W-1:0] wr_addr,
  input  sarl_pkg::entry_t          wr_entry,
  input  sarl_pkg::rd_req_t         rd_req,
  output sarl_pkg::entry_t          rd_data
);
  import sarl_pkg::*;

  entry_t mem [SYMBOLS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_req.en) begin
      rd_data <= mem[rd_req.addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sarl_scan.sv =====
// Scan sequencer: walks the table one entry a cycle through a shared range compare.
`default_nettype none

module sarl_scan (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [sarl_pkg::DATA_W-1:0] start_addr,
  input  logic [sarl_pkg::LIM_W-1:0]  start_limit,
  input  sarl_pkg::entry_t           rd_data,
  input  logic                       res_ready,
  output logic                       idle,
  output sarl_pkg::rd_req_t          rd_req,
  output sarl_pkg::scan_res_t        res
);
  import sarl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_HOLD = 3'b100
  } scan_state_t;

  scan_state_t        state;
  scan_state_t        state_next;
  logic [DATA_W-1:0]  addr;
  logic [LIM_W-1:0]   limit;
  logic [LIM_W-1:0]   issue;
  logic               rd_valid;
  logic [IDX_W-1:0]   pend_idx;
  logic               found;
  logic [MATCH_W-1:0] match;
  logic [DATA_W-1:0]  upper;
  logic               hit;
  logic               last;

  // Shared range compare: start <= addr < start + length, wrapped to 64 bits.
  assign upper = rd_data.start + rd_data.length;
  assign hit   = rd_valid && rd_data.usable && (addr >= rd_data.start) && (addr < upper);
  assign last  = rd_valid && (issue == limit);

  assign rd_req.en   = (state == S_SCAN) && (issue < limit);
  assign rd_req.addr = issue[IDX_W-1:0];

  assign idle      = (state == S_IDLE);
  assign res.valid = (state == S_HOLD);
  assign res.found = found;
  assign res.index = match;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = (start_limit == '0) ? S_HOLD : S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit || last) begin
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rd_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= rd_req.en;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      addr  <= start_addr;
      limit <= start_limit;
      issue <= '0;
      found <= 1'b0;
      match <= '0;
    end else if (state == S_SCAN) begin
      if (rd_req.en) begin
        issue    <= issue + LIM_W'(1);
        pend_idx <= issue[IDX_W-1:0];
      end
      if (hit) begin
        found <= 1'b1;
        match <= MATCH_W'(pend_idx);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/symbol_address_range_lookup.sv =====
// Top level: register file, table, scan sequencer and response register.
//
//   channel    dir   handshake        payload
//   setup      in    valid / ready    index, data (addr_offset, symbol_count)
//   request    in    valid / ready    command, entry fields, query_address
//   response   out   valid / ready    found, match_index
//
// A write item is written to the table at the accepting edge.
// A query scans entries in index order, one read a cycle, and stops at the first hit;
// it scans at most min(symbol_count, 1024) entries, none when symbol_count is zero.
// rst clears registers, the sequencer and the response valid, not the table.
// A stalled response waits in its own register while the next item is taken;
// a finished scan holds until that register frees up.
`default_nettype none

module symbol_address_range_lookup (
  input  logic        clk,
  input  logic        rst,
  sarl_cfg_if.sink    setup,
  sarl_in_if.sink     request,
  sarl_out_if.source  response
);
  import sarl_pkg::*;

  logic [DATA_W-1:0]  addr_offset;
  logic [COUNT_W-1:0] symbol_count;
  logic [LIM_W-1:0]   limit;

  logic               in_fire;
  logic               query_fire;
  logic               write_fire;
  logic               scan_idle;
  logic               res_ready;

  entry_t             wr_entry;
  entry_t             rd_data;
  rd_req_t            rd_req;
  scan_res_t          res;

  logic               out_valid;
  logic               out_found;
  logic [MATCH_W-1:0] out_index;

  // Register writes are always taken.
  assign setup.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      addr_offset  <= '0;
      symbol_count <= '0;
    end else if (setup.valid) begin
      case (setup.index)
        REG_ADDR_OFFSET:  addr_offset  <= setup.data;
        REG_SYMBOL_COUNT: symbol_count <= setup.data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the scan length to the table depth.
  assign limit = (32'(symbol_count) > SYMBOLS) ? LIM_W'(SYMBOLS) : LIM_W'(symbol_count);

  // Take an item only while the sequencer is idle.
  assign request.ready = scan_idle;
  assign in_fire       = request.valid && request.ready;
  assign query_fire    = in_fire && (request.command == CMD_QUERY);
  assign write_fire    = in_fire && (request.command == CMD_WRITE)
                         && (32'(request.entry_index) < SYMBOLS);

  // Fold section and kind into one usable bit at write time.
  assign wr_entry.start  = request.entry_start;
  assign wr_entry.length = request.entry_length;
  assign wr_entry.usable = (request.entry_section != SECTION_NONE)
                           && (request.entry_kind != STT_TLS);

  sarl_table u_table (
    .clk      (clk),
    .wr_en    (write_fire),
    .wr_addr  (IDX_W'(request.entry_index)),
    .wr_entry (wr_entry),
    .rd_req   (rd_req),
    .rd_data  (rd_data)
  );

  sarl_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .start       (query_fire),
    .start_addr  (request.query_address - addr_offset),
    .start_limit (limit),
    .rd_data     (rd_data),
    .res_ready   (res_ready),
    .idle        (scan_idle),
    .rd_req      (rd_req),
    .res         (res)
  );

  // Response register: load a finished scan when empty or being drained.
  assign res_ready = !out_valid || response.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (response.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      out_found <= res.found;
      out_index <= res.index;
    end
  end

  assign response.valid       = out_valid;
  assign response.found       = out_found;
  assign response.match_index = out_index;

`ifndef SYNTHESIS
  // A query keeps the block busy for at least the next cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    request.valid && request.ready && (request.command == CMD_QUERY) |=> !request.ready)
    else $error("request ready right after a query was taken");

  // A write item never produces a response.
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    request.valid && request.ready && (request.command == CMD_WRITE) && !response.valid
    |=> !response.valid)
    else $error("response appeared after a write item");

  // A miss reports index zero.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    response.valid && !response.found |-> response.match_index == '0)
    else $error("nonzero match_index on a miss");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_symbol_address_range_lookup.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the symbol address range lookup block.
module tb_symbol_address_range_lookup;
  import sarl_pkg::*;

  localparam int SETTLE_CYCLES = 8;    // quiet time before a register write
  localparam int TAIL_CYCLES   = 50;   // watch for stray results after the last one
  localparam int HOLD_CYCLES   = 400;  // long receiver hold-off to back up the block
  localparam int GROW_ITEMS    = 60;   // writes that extend the written prefix
  localparam int MAX_REPORTS   = 40;
  localparam logic [DATA_W-1:0] ALL_ONES = '1;

  typedef struct packed {
    logic                 cmd;
    logic [ENTRY_W-1:0]   idx;
    logic [DATA_W-1:0]    start;
    logic [DATA_W-1:0]    length;
    logic [SECTION_W-1:0] section;
    logic [KIND_W-1:0]    kind;
    logic [DATA_W-1:0]    addr;
  } req_item_t;

  typedef struct packed {
    logic               found;
    logic [MATCH_W-1:0] index;
  } lookup_res_t;

  // One line of the directed sequence: a register write or a request item,
  // optionally with a hand-written expected answer.
  typedef struct {
    bit                   is_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [DATA_W-1:0]    reg_val;
    req_item_t            item;
    bit                   typed;
    lookup_res_t          want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sarl_cfg_if setup ();
  sarl_in_if  request ();
  sarl_out_if response ();

  symbol_address_range_lookup DUT (
    .clk      (clk),
    .rst      (rst),
    .setup    (setup),
    .request  (request),
    .response (response)
  );

  always #1 clk = ~clk;

  // Shadow copy of the symbol table and the registers, updated as items are accepted.
  logic [DATA_W-1:0]  shadow_start  [SYMBOLS];
  logic [DATA_W-1:0]  shadow_length [SYMBOLS];
  bit                 shadow_usable [SYMBOLS];
  bit                 shadow_written[SYMBOLS];
  logic [DATA_W-1:0]  bias_reg;
  logic [COUNT_W-1:0] count_reg;
  int                 written_prefix;  // entries 0 .. written_prefix-1 all written

  lookup_res_t pending_results[$];

  int sender_idle_pct;
  int receiver_stall_pct;
  int hold_request;
  int hold_left;
  int n_writes, n_queries, n_hits, n_results, n_errors;

  function automatic logic [DATA_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Rebase the address, then walk the scanned entries in index order and
  // take the first usable one whose [start, start+length) range, wrapped
  // to 64 bits, holds it. A wrapped or zero length holds nothing.
  function automatic lookup_res_t resolve_address(input logic [DATA_W-1:0] abs_addr);
    lookup_res_t        r;
    logic [DATA_W-1:0]  a;
    logic [DATA_W-1:0]  hi;
    int                 lim;
    r   = '0;
    a   = abs_addr - bias_reg;
    lim = (count_reg > SYMBOLS) ? SYMBOLS : int'(count_reg);
    for (int i = 0; i < lim && !r.found; i++) begin
      hi = shadow_start[i] + shadow_length[i];
      if (shadow_usable[i] && a >= shadow_start[i] && a < hi) begin
        r.found = 1'b1;
        r.index = MATCH_W'(i);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input lookup_res_t got,
                                 input lookup_res_t want);
    n_errors++;
    if (n_errors <= MAX_REPORTS)
      $display("%0t ERROR %s got found=%0b index=%0d, expected found=%0b index=%0d",
               $time, what, got.found, got.index, want.found, want.index);
  endtask

  // Receiver: stall at random, or hold off entirely while a hold-off is running.
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      response.ready <= 1'b0;
    end else begin
      response.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Compare each accepted result with the oldest pending answer.
  always @(posedge clk) begin : check_response
    lookup_res_t got;
    lookup_res_t want;
    if (!rst && response.valid === 1'b1 && response.ready === 1'b1) begin
      got.found = response.found;
      got.index = response.match_index;
      n_results++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending:", got, '0);
      end else begin
        want = pending_results.pop_front();
        if (got.found !== want.found || got.index !== want.index)
          report_mismatch("wrong result:", got, want);
      end
    end
  end

  // Offer one item, idling first at the current rate, and hold it until taken.
  // Valid stays high on return so that a following item goes out back to back.
  task automatic issue_item(input req_item_t it, input bit typed, input lookup_res_t want);
    lookup_res_t res;
    while ($urandom_range(99) < sender_idle_pct) begin
      request.valid <= 1'b0;
      @(posedge clk);
    end
    request.valid         <= 1'b1;
    request.command       <= it.cmd;
    request.entry_index   <= it.idx;
    request.entry_start   <= it.start;
    request.entry_length  <= it.length;
    request.entry_section <= it.section;
    request.entry_kind    <= it.kind;
    request.query_address <= it.addr;
    @(posedge clk);
    while (request.ready !== 1'b1) @(posedge clk);
    if (it.cmd == CMD_WRITE) begin
      shadow_start[it.idx]   = it.start;
      shadow_length[it.idx]  = it.length;
      shadow_usable[it.idx]  = (it.section != SECTION_NONE) && (it.kind != STT_TLS);
      shadow_written[it.idx] = 1'b1;
      while (written_prefix < SYMBOLS && shadow_written[written_prefix]) written_prefix++;
      n_writes++;
    end else begin
      res = typed ? want : resolve_address(it.addr);
      if (res.found) n_hits++;
      pending_results = {pending_results, res};
      n_queries++;
    end
  endtask

  // Drop valid and wait for every pending result; always wait for a clock edge first
  // so a following valid never lands in the same step as this drop.
  task automatic drain();
    request.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    setup.valid <= 1'b1;
    setup.index <= idx;
    setup.data  <= val;
    @(posedge clk);
    while (setup.ready !== 1'b1) @(posedge clk);
    setup.valid <= 1'b0;
    if (idx == REG_ADDR_OFFSET)
      bias_reg = val;
    else if (idx == REG_SYMBOL_COUNT)
      count_reg = val[COUNT_W-1:0];
  endtask

  // Build a random item. Writes mostly extend the written prefix or rewrite
  // scanned entries; queries mostly aim at the edges of a scanned entry.
  function automatic req_item_t pick_request(input int write_pct);
    req_item_t         it;
    int                lim;
    int                j;
    logic [DATA_W-1:0] rel;
    logic [DATA_W-1:0] span;
    it.idx     = ENTRY_W'($urandom_range(SYMBOLS - 1));
    it.start   = rand64();
    it.length  = rand64();
    it.section = SECTION_W'($urandom);
    it.kind    = KIND_W'($urandom);
    it.addr    = rand64();
    lim = (count_reg > SYMBOLS) ? SYMBOLS : int'(count_reg);
    if ($urandom_range(99) < write_pct) begin
      it.cmd = CMD_WRITE;
      case ($urandom_range(9))
        0, 1, 2, 3, 4: if (written_prefix < SYMBOLS) it.idx = ENTRY_W'(written_prefix);
        5, 6, 7:       if (lim > 0) it.idx = ENTRY_W'($urandom_range(lim - 1));
        default:       ;
      endcase
      case ($urandom_range(4))
        0:       it.start = rand64();
        1:       it.start = 64'h1000 + $urandom_range(4095);
        2:       it.start = 64'h7fff_ffff_0000_0000 + $urandom_range(4095);
        3:       it.start = 64'hffff_ffff_ffff_f000 + $urandom_range(4095);
        default: it.start = 64'($urandom_range(255));
      endcase
      case ($urandom_range(19))
        0, 1:    it.length = '0;
        2, 3:    it.length = rand64();
        4:       it.length = ALL_ONES;
        default: it.length = 64'($urandom_range(256, 1));
      endcase
      if ($urandom_range(99) < 15) it.section = SECTION_NONE;
      if ($urandom_range(99) < 15) it.kind = STT_TLS;
    end else begin
      it.cmd = CMD_QUERY;
      if (lim > 0 && $urandom_range(99) < 75) begin
        j    = $urandom_range(lim - 1);
        span = shadow_length[j];
        case ($urandom_range(4))
          0:       rel = shadow_start[j] - 1;
          1:       rel = shadow_start[j];
          2:       rel = shadow_start[j] + span - 1;
          3:       rel = shadow_start[j] + span;
          default: rel = shadow_start[j] + ((span == 0) ? '0 : rand64() % span);
        endcase
        it.addr = rel + bias_reg;
      end else if ($urandom_range(1) == 0) begin
        it.addr = 64'h1000 + $urandom_range(8191) + bias_reg;
      end
    end
    return it;
  endfunction

  task automatic run_random(input int items, input int write_pct);
    for (int k = 0; k < items; k++) issue_item(pick_request(write_pct), 1'b0, '0);
  endtask

  function automatic plan_row_t blank_row();
    plan_row_t r;
    r.is_reg  = 1'b0;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.item    = '0;
    r.typed   = 1'b0;
    r.want    = '0;
    return r;
  endfunction

  function automatic plan_row_t row_write(input int idx, input logic [DATA_W-1:0] s,
                                          input logic [DATA_W-1:0] l, input int sec,
                                          input int kd);
    plan_row_t r;
    r = blank_row();
    r.item.cmd     = CMD_WRITE;
    r.item.idx     = ENTRY_W'(idx);
    r.item.start   = s;
    r.item.length  = l;
    r.item.section = SECTION_W'(sec);
    r.item.kind    = KIND_W'(kd);
    return r;
  endfunction

  function automatic plan_row_t row_query(input logic [DATA_W-1:0] a);
    plan_row_t r;
    r = blank_row();
    r.item.cmd  = CMD_QUERY;
    r.item.addr = a;
    return r;
  endfunction

  function automatic plan_row_t row_answer(input logic [DATA_W-1:0] a, input bit hit,
                                           input int idx);
    plan_row_t r;
    r = row_query(a);
    r.typed      = 1'b1;
    r.want.found = hit;
    r.want.index = MATCH_W'(idx);
    return r;
  endfunction

  function automatic plan_row_t row_reg(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [DATA_W-1:0] val);
    plan_row_t r;
    r = blank_row();
    r.is_reg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // Run limit: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("symbol_address_range_lookup test failed");
    $finish;
  end

  initial begin : main
    plan_row_t plan[$];
    req_item_t fill;

    // Hold every input at a known value from time zero.
    request.valid         = 1'b0;
    request.command       = CMD_WRITE;
    request.entry_index   = '0;
    request.entry_start   = '0;
    request.entry_length  = '0;
    request.entry_section = '0;
    request.entry_kind    = '0;
    request.query_address = '0;
    setup.valid           = 1'b0;
    setup.index           = REG_ADDR_OFFSET;
    setup.data            = '0;
    response.ready        = 1'b0;
    bias_reg              = '0;
    count_reg             = '0;
    written_prefix        = 0;
    sender_idle_pct       = 0;
    receiver_stall_pct    = 0;
    hold_request          = 0;
    hold_left             = 0;
    n_writes = 0; n_queries = 0; n_hits = 0; n_results = 0; n_errors = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. With nothing scanned after reset every query misses.
    plan = {plan, row_answer('0, 1'b0, 0)};
    plan = {plan, row_answer(ALL_ONES, 1'b0, 0)};
    // Plain entry, empty range, undefined section, thread-local, wrapping range,
    // range ending at the top, range covering nearly everything, one-byte range.
    plan = {plan, row_write(0, 64'h1000, 64'h100, 1, 2)};
    plan = {plan, row_write(1, 64'h0, 64'h0, 16'hffff, 0)};
    plan = {plan, row_write(2, 64'h1000, 64'h10, SECTION_NONE, 1)};
    plan = {plan, row_write(3, 64'h1080, 64'h100, 5, STT_TLS)};
    plan = {plan, row_write(4, 64'hffff_ffff_ffff_ff00, 64'h200, 3, 15)};
    plan = {plan, row_write(5, 64'hffff_ffff_ffff_ff00, 64'hff, 16'hffff, 0)};
    plan = {plan, row_write(6, 64'h0, ALL_ONES, 1, 7)};
    plan = {plan, row_write(7, 64'h2000, 64'h1, 2, 5)};
    plan = {plan, row_write(SYMBOLS - 1, ALL_ONES, ALL_ONES, 16'hffff, 15)};
    plan = {plan, row_reg(REG_SYMBOL_COUNT, 8)};
    plan = {plan, row_answer(64'h1000, 1'b1, 0)};
    plan = {plan, row_answer(64'h10ff, 1'b1, 0)};
    plan = {plan, row_query(64'h1100)};
    plan = {plan, row_answer(ALL_ONES, 1'b0, 0)};
    plan = {plan, row_query(64'hffff_ffff_ffff_ff80)};
    plan = {plan, row_query(64'h2000)};
    plan = {plan, row_reg(REG_ADDR_OFFSET, 64'hffff_ffff_ffff_f000)};
    plan = {plan, row_query(64'h0)};
    plan = {plan, row_reg(REG_ADDR_OFFSET, ALL_ONES)};
    plan = {plan, row_query(64'hfff)};
    plan = {plan, row_reg(REG_SYMBOL_COUNT, 1)};
    plan = {plan, row_query(64'h1100)};
    plan = {plan, row_reg(REG_ADDR_OFFSET, 0)};

    foreach (plan[r]) begin
      if (plan[r].is_reg)
        set_register(plan[r].reg_idx, plan[r].reg_val);
      else
        issue_item(plan[r].item, plan[r].typed, plan[r].want);
    end

    // Random part. The scan count never reaches past the written prefix,
    // so no query ever touches an entry that was never written.

    // No idling on either side.
    set_register(REG_ADDR_OFFSET, rand64());
    set_register(REG_SYMBOL_COUNT, 64'(written_prefix));
    run_random(90, 35);

    // Sender idles about half the time; pause once until all results are back.
    sender_idle_pct = 52;
    set_register(REG_ADDR_OFFSET, 0);
    set_register(REG_SYMBOL_COUNT, 64'((written_prefix > 96) ? 96 : written_prefix));
    run_random(45, 35);
    drain();
    run_random(45, 35);

    // Receiver stalls about half the time, then holds off for a long stretch
    // while queries keep coming, so the block backs up and stalls its input.
    sender_idle_pct    = 0;
    receiver_stall_pct = 52;
    set_register(REG_ADDR_OFFSET, ALL_ONES);
    set_register(REG_SYMBOL_COUNT, 64'((written_prefix > 96) ? 96 : written_prefix));
    run_random(40, 30);
    hold_request = HOLD_CYCLES;
    run_random(20, 0);
    run_random(30, 30);

    // Extend the written prefix, then scan all of it.
    receiver_stall_pct = 0;
    for (int i = 0; i < GROW_ITEMS; i++) begin
      if (written_prefix < SYMBOLS) begin
        fill     = pick_request(100);
        fill.idx = ENTRY_W'(written_prefix);
        issue_item(fill, 1'b0, '0);
      end
    end
    set_register(REG_ADDR_OFFSET, 0);
    set_register(REG_SYMBOL_COUNT, 64'(written_prefix));
    run_random(14, 0);

    // Both sides idle about a quarter of the time.
    sender_idle_pct    = 27;
    receiver_stall_pct = 27;
    set_register(REG_SYMBOL_COUNT, 64'((written_prefix > 64) ? 64 : written_prefix));
    run_random(90, 35);

    // Receiver stalls with a deeper scan.
    sender_idle_pct    = 0;
    receiver_stall_pct = 52;
    set_register(REG_ADDR_OFFSET, rand64());
    set_register(REG_SYMBOL_COUNT, 64'((written_prefix > 200) ? 200 : written_prefix));
    run_random(80, 35);

    // Sender idles with the shortest useful scan.
    sender_idle_pct    = 52;
    receiver_stall_pct = 0;
    set_register(REG_SYMBOL_COUNT, 1);
    run_random(60, 35);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d table writes and %0d queries (%0d hits) across idle, stall and hold-off",
             n_writes, n_queries, n_hits);
    $display("mixes, bias extremes and scan counts from none to %0d entries; %0d checked.",
             written_prefix, n_results);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("symbol_address_range_lookup test passed");
    end else begin
      $display("symbol_address_range_lookup test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sarl_pkg.sv
rtl/sarl_ifs.sv
rtl/sarl_table.sv
rtl/sarl_scan.sv
rtl/symbol_address_range_lookup.sv
dv/tb_symbol_address_range_lookup.sv
